[sv/slps_pkg.sv]
package slps_pkg;

  localparam int unsigned MsW  = 11;
  localparam int unsigned RepW = 4;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLIENT = 2'd2;

  localparam logic [2:0] PAT_READY   = 3'd0;
  localparam logic [2:0] PAT_CONNECT = 3'd1;
  localparam logic [2:0] PAT_NORMAL  = 3'd2;
  localparam logic [2:0] PAT_NO_NET  = 3'd3;
  localparam logic [2:0] PAT_SAVING  = 3'd4;
  localparam logic [2:0] PAT_FACTORY = 3'd5;
  localparam logic [2:0] PAT_ERROR   = 3'd6;
  localparam logic [2:0] PAT_CLIENT  = 3'd7;

  typedef struct packed {
    logic [RepW-1:0] blinks;
    logic            level;
    logic [MsW-1:0]  on_ms;
    logic [MsW-1:0]  off_ms;
  } seg_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic            pend;
    logic [2:0]      pat;
    logic            busy;
    logic            phase;
    logic [RepW-1:0] rep;
    logic [MsW-1:0]  ms;
    logic            led;
  } state_t;

  function automatic seg_t mk_seg(input logic [RepW-1:0] blinks, input logic level,
                                  input logic [MsW-1:0] on_ms, input logic [MsW-1:0] off_ms);
    seg_t s;
    s.blinks = blinks;
    s.level  = level;
    s.on_ms  = on_ms;
    s.off_ms = off_ms;
    return s;
  endfunction

  function automatic seg_t seg_get(input logic [2:0] pat, input logic phase);
    seg_t s;
    s = mk_seg(4'd0, 1'b0, 11'd0, 11'd0);
    case (pat)
      PAT_READY:   if (!phase) s = mk_seg(4'd1, 1'b1, 11'd2000, 11'd300);
      PAT_CONNECT: if (!phase) s = mk_seg(4'd1, 1'b1, 11'd500, 11'd500);
      PAT_NORMAL:  if (!phase) s = mk_seg(4'd0, 1'b1, 11'd500, 11'd0);
      PAT_NO_NET:  s = phase ? mk_seg(4'd0, 1'b0, 11'd2000, 11'd0)
                             : mk_seg(4'd2, 1'b1, 11'd120, 11'd120);
      PAT_SAVING:  if (!phase) s = mk_seg(4'd1, 1'b1, 11'd100, 11'd100);
      PAT_FACTORY: s = phase ? mk_seg(4'd2, 1'b1, 11'd700, 11'd300)
                             : mk_seg(4'd15, 1'b1, 11'd100, 11'd100);
      PAT_ERROR:   s = phase ? mk_seg(4'd0, 1'b0, 11'd2000, 11'd0)
                             : mk_seg(4'd3, 1'b1, 11'd120, 11'd120);
      PAT_CLIENT:  s = phase ? mk_seg(4'd5, 1'b1, 11'd120, 11'd120)
                             : mk_seg(4'd0, 1'b1, 11'd1000, 11'd0);
      default:     s = mk_seg(4'd0, 1'b0, 11'd0, 11'd0);
    endcase
    return s;
  endfunction

  function automatic logic two_phases(input logic [2:0] pat);
    logic r;
    case (pat)
      PAT_NO_NET, PAT_FACTORY, PAT_ERROR, PAT_CLIENT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[sv/slps_step.sv]
module slps_step (
  input  slps_pkg::state_t cur,
  input  logic [1:0]       req_type,
  input  logic [2:0]       new_mode,
  output slps_pkg::state_t nxt,
  output logic             lit
);
  import slps_pkg::*;

  seg_t       seg_c;
  seg_t       seg_1;
  seg_t       seg_s;
  logic [2:0] pat_s;

  always_comb begin
    pat_s = cur.pend ? PAT_CLIENT : ((cur.mode >= PAT_ERROR) ? PAT_ERROR : cur.mode);
    seg_s = seg_get(pat_s, 1'b0);
    seg_c = seg_get(cur.pat, cur.phase);
    seg_1 = seg_get(cur.pat, 1'b1);
    nxt   = cur;
    lit   = cur.led;
    case (req_type)
      REQ_TICK: begin
        if (!cur.busy) begin
          // start a new pattern and spend its first millisecond
          nxt.pend  = 1'b0;
          nxt.pat   = pat_s;
          nxt.busy  = 1'b1;
          nxt.phase = 1'b0;
          nxt.led   = (seg_s.blinks != '0) ? 1'b1 : seg_s.level;
          nxt.rep   = seg_s.blinks;
          nxt.ms    = seg_s.on_ms - MsW'(1);
          lit       = nxt.led;
        end else if (cur.ms <= MsW'(1)) begin
          if (seg_c.blinks != '0 && cur.led) begin
            nxt.led = 1'b0;
            nxt.ms  = seg_c.off_ms;
          end else if (seg_c.blinks != '0 && cur.rep > RepW'(1)) begin
            nxt.rep = cur.rep - RepW'(1);
            nxt.led = 1'b1;
            nxt.ms  = seg_c.on_ms;
          end else if (!cur.phase && two_phases(cur.pat)) begin
            nxt.phase = 1'b1;
            nxt.led   = (seg_1.blinks != '0) ? 1'b1 : seg_1.level;
            nxt.ms    = seg_1.on_ms;
            nxt.rep   = seg_1.blinks;
          end else begin
            // pattern done
            nxt.busy = 1'b0;
            nxt.rep  = '0;
            nxt.ms   = '0;
            if (cur.pat == PAT_FACTORY) begin
              nxt.mode = PAT_READY;
            end
          end
        end else begin
          nxt.ms = cur.ms - MsW'(1);
        end
      end
      REQ_SET:    nxt.mode = new_mode;
      REQ_CLIENT: nxt.pend = 1'b1;
      default:    nxt = cur;
    endcase
  end

endmodule

[sv/status_led_pattern_sequencer.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | in_req_type, in_new_mode
// out_    | output    | out_valid / out_stall | out_led_on, out_pattern_busy, out_current_mode
//
// One request per cycle while in_stall is low: a request is held in an input
// register, then the pattern state and the result register update together
// once the result register is empty or out_stall is low.
// rst_n is synchronous, active low, and clears the pattern state and valids.
// in_stall rises only while both the input register and the result register
// hold requests and out_stall is high.
module status_led_pattern_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_new_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_led_on,
  output logic       out_pattern_busy,
  output logic [2:0] out_current_mode
);
  import slps_pkg::*;

  logic       s1_v_r;
  logic [1:0] s1_req_r;
  logic [2:0] s1_mode_r;
  state_t     st_r;
  state_t     st_nxt;
  logic       lit_nxt;
  logic       out_v_r;
  logic       led_r;
  logic       busy_r;
  logic [2:0] mode_r;
  logic       adv;
  logic       take;

  assign adv      = !out_v_r || !out_stall;
  assign take     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;

  slps_step u_step (
    .cur      (st_r),
    .req_type (s1_req_r),
    .new_mode (s1_mode_r),
    .nxt      (st_nxt),
    .lit      (lit_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (take) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r  <= in_req_type;
      s1_mode_r <= in_new_mode;
    end
    if (take) begin
      led_r  <= lit_nxt;
      busy_r <= st_nxt.busy;
      mode_r <= st_nxt.mode;
    end
  end

  assign out_valid        = out_v_r;
  assign out_led_on       = led_r;
  assign out_pattern_busy = busy_r;
  assign out_current_mode = mode_r;

endmodule

[tb/sv/led_pattern_checker.sv]
module led_pattern_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_new_mode,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_led_on,
  input  logic       out_pattern_busy,
  input  logic [2:0] out_current_mode,
  output int         mismatch_count,
  output int         results_waiting,
  output int         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import slps_pkg::*;

  typedef struct packed {
    logic       led;
    logic       busy;
    logic [2:0] mode;
  } led_status_t;

  typedef struct packed {
    logic [3:0]  blinks;
    logic        level;
    logic [10:0] on_ms;
    logic [10:0] off_ms;
  } phase_shape_t;

  logic [2:0]  mode_q;
  logic        pend_q;
  logic [2:0]  pat_q;
  logic        busy_q;
  logic [1:0]  phase_q;
  logic [3:0]  rep_q;
  logic [10:0] ms_q;
  logic        led_q;

  led_status_t expected_status[$];
  int          fails_seen = 0;
  int          checked_n = 0;

  function automatic phase_shape_t shape_of(input logic [2:0] pat, input logic second);
    phase_shape_t s;
    s = '0;
    case ({pat, second})
      {PAT_READY, 1'b0}:   s = {4'd1, 1'b1, 11'd2000, 11'd300};
      {PAT_CONNECT, 1'b0}: s = {4'd1, 1'b1, 11'd500, 11'd500};
      {PAT_NORMAL, 1'b0}:  s = {4'd0, 1'b1, 11'd500, 11'd0};
      {PAT_NO_NET, 1'b0}:  s = {4'd2, 1'b1, 11'd120, 11'd120};
      {PAT_NO_NET, 1'b1}:  s = {4'd0, 1'b0, 11'd2000, 11'd0};
      {PAT_SAVING, 1'b0}:  s = {4'd1, 1'b1, 11'd100, 11'd100};
      {PAT_FACTORY, 1'b0}: s = {4'd15, 1'b1, 11'd100, 11'd100};
      {PAT_FACTORY, 1'b1}: s = {4'd2, 1'b1, 11'd700, 11'd300};
      {PAT_ERROR, 1'b0}:   s = {4'd3, 1'b1, 11'd120, 11'd120};
      {PAT_ERROR, 1'b1}:   s = {4'd0, 1'b0, 11'd2000, 11'd0};
      {PAT_CLIENT, 1'b0}:  s = {4'd0, 1'b1, 11'd1000, 11'd0};
      {PAT_CLIENT, 1'b1}:  s = {4'd5, 1'b1, 11'd120, 11'd120};
      default:             s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] phase_count(input logic [2:0] pat);
    logic [1:0] n;
    case (pat)
      PAT_NO_NET, PAT_FACTORY, PAT_ERROR, PAT_CLIENT: n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  task automatic enter_phase();
    phase_shape_t s;
    s = shape_of(pat_q, phase_q[0]);
    led_q = (s.blinks == 4'd0) ? s.level : 1'b1;
    ms_q  = s.on_ms;
    rep_q = s.blinks;
  endtask

  task automatic advance_half();
    phase_shape_t s;
    s = shape_of(pat_q, phase_q[0]);
    if (s.blinks != 4'd0 && led_q) begin
      led_q = 1'b0;
      ms_q  = s.off_ms;
    end else if (s.blinks != 4'd0 && rep_q > 4'd1) begin
      rep_q = rep_q - 4'd1;
      led_q = 1'b1;
      ms_q  = s.on_ms;
    end else if (phase_q + 2'd1 < phase_count(pat_q)) begin
      phase_q = phase_q + 2'd1;
      enter_phase();
    end else begin
      busy_q = 1'b0;
      rep_q  = 4'd0;
      ms_q   = 11'd0;
      if (pat_q == PAT_FACTORY) mode_q = PAT_READY;
    end
  endtask

  task automatic predict_led_status(input logic [1:0] rt, input logic [2:0] nm,
                                    output led_status_t r);
    logic lit;
    lit = led_q;
    case (rt)
      REQ_TICK: begin
        if (!busy_q) begin
          if (pend_q) begin
            pend_q = 1'b0;
            pat_q  = PAT_CLIENT;
          end else begin
            pat_q = (mode_q >= PAT_ERROR) ? PAT_ERROR : mode_q;
          end
          busy_q  = 1'b1;
          phase_q = 2'd0;
          enter_phase();
        end
        lit = led_q;
        if (ms_q <= 11'd1) advance_half();
        else ms_q = ms_q - 11'd1;
      end
      REQ_SET:    mode_q = nm;
      REQ_CLIENT: pend_q = 1'b1;
      default:    ;
    endcase
    r = {lit, busy_q, mode_q};
  endtask

  always @(posedge clk) begin : watch
    led_status_t got;
    led_status_t want;
    if (!rst_n) begin
      mode_q  = PAT_READY;
      pend_q  = 1'b0;
      pat_q   = PAT_READY;
      busy_q  = 1'b0;
      phase_q = 2'd0;
      rep_q   = 4'd0;
      ms_q    = 11'd0;
      led_q   = 1'b0;
      expected_status.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_led_on, out_pattern_busy, out_current_mode};
        if (expected_status.size() == 0) begin
          fails_seen++;
          if (fails_seen <= 10)
            $display("%0t: unexpected result led=%0d busy=%0d mode=%0d", $realtime,
                     got.led, got.busy, got.mode);
        end else begin
          want = expected_status.pop_front();
          checked_n++;
          if (got !== want) begin
            fails_seen++;
            if (fails_seen <= 10)
              $display("%0t: mismatch, expected led=%0d busy=%0d mode=%0d, got led=%0d busy=%0d mode=%0d",
                       $realtime, want.led, want.busy, want.mode,
                       got.led, got.busy, got.mode);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_led_status(in_req_type, in_new_mode, want);
        expected_status.push_back(want);
      end
    end
    mismatch_count  <= fails_seen;
    results_checked <= checked_n;
    results_waiting <= expected_status.size();
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slps_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PROFILE = 190;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_TICK;
  logic [2:0] in_new_mode = PAT_READY;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_led_on;
  logic       out_pattern_busy;
  logic [2:0] out_current_mode;

  int mismatch_count;
  int results_waiting;
  int results_checked;
  int send_idle_pct = 34;
  int recv_idle_pct = 70;
  int quiet_cycles = 0;
  int sent_by_kind[4] = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  status_led_pattern_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_new_mode      (in_new_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_led_on       (out_led_on),
    .out_pattern_busy (out_pattern_busy),
    .out_current_mode (out_current_mode)
  );

  led_pattern_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_new_mode      (in_new_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_led_on       (out_led_on),
    .out_pattern_busy (out_pattern_busy),
    .out_current_mode (out_current_mode),
    .mismatch_count   (mismatch_count),
    .results_waiting  (results_waiting),
    .results_checked  (results_checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] rt, input logic [2:0] nm);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_req_type <= 2'($urandom_range(3));
      in_new_mode <= 3'($urandom_range(7));
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_new_mode <= nm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_by_kind[rt]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_mode();
    int roll;
    logic [2:0] m;
    roll = $urandom_range(99);
    if (roll < 35) m = PAT_SAVING;
    else if (roll < 55) m = PAT_NORMAL;
    else m = 3'($urandom_range(7));
    return m;
  endfunction

  task automatic tick_burst(input int n);
    int k;
    for (k = 0; k < n; k++) issue(REQ_TICK, 3'($urandom_range(7)));
  endtask

  task automatic random_profile(input int n_items);
    int sent;
    int roll;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        issue(REQ_SET, pick_mode());
        sent++;
      end else if (roll < 65) begin
        issue(REQ_CLIENT, 3'($urandom_range(7)));
        sent++;
      end else if (roll < 73) begin
        issue(REQ_UNUSED, 3'($urandom_range(7)));
        sent++;
      end
      roll = $urandom_range(99);
      if (roll < 70) burst = $urandom_range(12);
      else burst = $urandom_range(120, 40);
      if (burst > n_items - sent) burst = n_items - sent;
      tick_burst(burst);
      sent += burst;
    end
  endtask

  initial begin
    int m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(REQ_SET, PAT_SAVING);
    issue(REQ_TICK, 3'd0);
    issue(REQ_TICK, 3'd7);
    issue(REQ_SET, PAT_FACTORY);
    issue(REQ_CLIENT, 3'd0);
    issue(REQ_UNUSED, 3'd7);
    issue(REQ_UNUSED, 3'd0);
    issue(REQ_TICK, 3'd5);
    for (m = 0; m < 8; m++) issue(REQ_SET, 3'(m));
    issue(REQ_TICK, 3'd2);
    issue(REQ_SET, PAT_SAVING);
    issue(REQ_CLIENT, 3'd7);
    tick_burst(4);

    random_profile(ITEMS_PER_PROFILE);
    drain_results();

    send_idle_pct = 70;
    recv_idle_pct = 34;
    random_profile(ITEMS_PER_PROFILE);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_profile(ITEMS_PER_PROFILE);
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d ticks, %0d mode sets, %0d client events, %0d unused codes",
             sent_by_kind[REQ_TICK], sent_by_kind[REQ_SET], sent_by_kind[REQ_CLIENT],
             sent_by_kind[REQ_UNUSED]);
    $display("%0d results compared over three stall profiles, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
